// File: hdl/b2da_pkg.sv
package b2da_pkg;

  // Widths of the beat payloads.
  localparam int ValueW = 32;
  localparam int CharW  = 6;

  // Ten BCD digits cover every 32-bit value.
  localparam int BcdDigits = 10;
  localparam int BcdW      = 4 * BcdDigits;
  localparam int DigitIdxW = $clog2(BcdDigits);

  // ASCII code of the character zero.
  localparam logic [CharW-1:0] AsciiZero = CharW'(48);

  // Default depth of the queue between front and back.
  localparam int QueueDepthDef = 2;

  // One queued item: the value and its classification.
  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              is_zero;
  } q_entry_t;

endpackage

// File: hdl/b2da_if.sv
interface b2da_in_if;
  logic                        valid;
  logic                        ready;
  logic [b2da_pkg::ValueW-1:0] value;

  modport source(output valid, output value, input ready);
  modport sink(input valid, input value, output ready);
endinterface

interface b2da_out_if;
  logic                       valid;
  logic                       ready;
  logic [b2da_pkg::CharW-1:0] digit_char;
  logic                       last;

  modport source(output valid, output digit_char, output last, input ready);
  modport sink(input valid, input digit_char, input last, output ready);
endinterface

// File: hdl/b2da_front.sv
module b2da_front #(
  parameter int QDepth = b2da_pkg::QueueDepthDef
) (
  input  logic               clk,
  input  logic               rst_n,
  b2da_in_if.sink            in_ch,
  output logic               q_valid,
  output b2da_pkg::q_entry_t q_head,
  input  logic               q_pop
);

  localparam int PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int CntW = $clog2(QDepth + 1);

  b2da_pkg::q_entry_t mem_r [QDepth];

  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r,  count_nxt;
  logic            push;
  logic            pop;

  // Accept a beat whenever the queue has room.
  assign in_ch.ready = (count_r != CntW'(QDepth));
  assign push        = in_ch.valid && in_ch.ready;
  assign pop         = q_pop && q_valid;

  assign q_valid = (count_r != '0);
  assign q_head  = mem_r[rd_ptr_r];

  // Pointer and fill-count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(QDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(QDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the value with its zero classification.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r].value   <= in_ch.value;
      mem_r[wr_ptr_r].is_zero <= (in_ch.value == '0);
    end
  end

  // The fill count never passes the queue depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(QDepth))
    else $error("queue fill count out of range");

endmodule

// File: hdl/b2da_back.sv
module b2da_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  b2da_pkg::q_entry_t q_head,
  output logic               q_pop,
  b2da_out_if.source         out_ch
);

  localparam int ValueW    = b2da_pkg::ValueW;
  localparam int BcdW      = b2da_pkg::BcdW;
  localparam int IdxW      = b2da_pkg::DigitIdxW;
  localparam int CntW      = $clog2(ValueW);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SHIFT = 3'b010,
    ST_EMIT  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [ValueW-1:0]          bin_r,     bin_nxt;
  logic [BcdW-1:0]            bcd_r,     bcd_nxt;
  logic [BcdW-1:0]            bcd_adj;
  logic [CntW-1:0]            cnt_r,     cnt_nxt;
  logic [IdxW-1:0]            idx_r,     idx_nxt;
  logic                       started_r, started_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [b2da_pkg::CharW-1:0] out_char_r,  out_char_nxt;
  logic                       out_last_r,  out_last_nxt;
  logic [3:0]                 cur_digit;
  logic                       show;
  logic                       slot_free;
  logic                       bcd_ok;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.digit_char = out_char_r;
  assign out_ch.last       = out_last_r;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign cur_digit = bcd_r[BcdW-1 -: 4];
  assign show      = started_r || (cur_digit != 4'd0) || (idx_r == '0);

  // Add three to every BCD digit of five or more before the next shift.
  always_comb begin
    for (int i = 0; i < b2da_pkg::BcdDigits; i++) begin
      bcd_adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? bcd_r[4*i +: 4] + 4'd3
                                                      : bcd_r[4*i +: 4];
    end
  end

  // Every BCD digit stays a decimal digit.
  always_comb begin
    bcd_ok = 1'b1;
    for (int i = 0; i < b2da_pkg::BcdDigits; i++) begin
      if (bcd_r[4*i +: 4] > 4'd9) begin
        bcd_ok = 1'b0;
      end
    end
  end

  // Sequencer: load, shift-and-correct (skipped for a zero), then emit digits from the top.
  always_comb begin
    state_nxt     = state_r;
    bin_nxt       = bin_r;
    bcd_nxt       = bcd_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    started_nxt   = started_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    q_pop         = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop       = 1'b1;
          bcd_nxt     = '0;
          started_nxt = 1'b0;
          if (q_head.is_zero) begin
            idx_nxt   = '0;
            state_nxt = ST_EMIT;
          end else begin
            bin_nxt   = q_head.value;
            cnt_nxt   = CntW'(ValueW - 1);
            state_nxt = ST_SHIFT;
          end
        end
      end
      ST_SHIFT: begin
        bcd_nxt = {bcd_adj[BcdW-2:0], bin_r[ValueW-1]};
        bin_nxt = {bin_r[ValueW-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          idx_nxt   = IdxW'(b2da_pkg::BcdDigits - 1);
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!show || slot_free) begin
          if (show) begin
            out_valid_nxt = 1'b1;
            out_char_nxt  = b2da_pkg::AsciiZero + {2'b00, cur_digit};
            out_last_nxt  = (idx_r == '0);
            started_nxt   = 1'b1;
          end
          bcd_nxt = {bcd_r[BcdW-5:0], 4'd0};
          idx_nxt = idx_r - 1'b1;
          if (idx_r == '0) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r      <= bin_nxt;
    bcd_r      <= bcd_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  // A queued item is taken only when the sequencer is free.
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == ST_IDLE))
    else $error("queue popped while busy");

  // The BCD register never holds a non-decimal digit while converting.
  a_bcd_digits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHIFT || state_r == ST_EMIT) |-> bcd_ok)
    else $error("BCD digit out of range");

  // Emitted characters are decimal digits.
  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_char_r >= b2da_pkg::AsciiZero) &&
                    (out_char_r <= b2da_pkg::AsciiZero + 6'd9))
    else $error("emitted character is not a digit");

  // Leaving the emit phase always coincides with a beat marked last.
  a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && state_nxt == ST_IDLE) |=> (out_valid_r && out_last_r))
    else $error("run ended without a last digit");

endmodule

// File: hdl/binary_to_decimal_ascii.sv
// Converts a 32-bit unsigned value to its decimal ASCII digits, most significant first.
// Each nonzero value takes one load, 32 double-dabble shifts and ten digit positions;
// a zero skips the shifts and emits the single digit 0. Digits stall while the output
// is not ready. The queue keeps accepting values while the back end converts, but a new
// value is taken from the queue only once the last digit of the previous run is registered.
// Reset is synchronous and active low; it empties the queue and the output stage.
module binary_to_decimal_ascii #(
  parameter int QDepth = b2da_pkg::QueueDepthDef
) (
  input  logic        clk,
  input  logic        rst_n,
  b2da_in_if.sink     in_ch,
  b2da_out_if.source  out_ch
);

  logic               q_valid;
  logic               q_pop;
  b2da_pkg::q_entry_t q_head;

  // Front end: accepts beats and classifies them into the queue.
  b2da_front #(
    .QDepth(QDepth)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_valid(q_valid),
    .q_head (q_head),
    .q_pop  (q_pop)
  );

  // Back end: converts to BCD and emits the digit run.
  b2da_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_valid(q_valid),
    .q_head (q_head),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

endmodule
